[hw/rtl/max_priority_queue_array_assert.svh]
// Assertion macros for the priority queue block
`ifndef MAX_PRIORITY_QUEUE_ARRAY_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ARRAY_ASSERT_SVH

// same-cycle implication
`define MPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("priority queue assertion failed");

// next-cycle implication
`define MPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("priority queue assertion failed");

`endif

[hw/rtl/mpq_pkg.sv]
package mpq_pkg;

  localparam int DEPTH          = 16;
  localparam int VALUE_BITS     = 32;
  localparam int IDX_BITS       = $clog2(DEPTH);
  localparam int COUNT_BITS     = $clog2(DEPTH + 1);
  localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [COUNT_BITS-1:0]        count_t;
  typedef logic [1:0]                   code_t;

  localparam code_t OP_INSERT = 2'd0;
  localparam code_t OP_REMOVE = 2'd1;
  localparam code_t OP_PEEK   = 2'd2;

  localparam code_t ST_OK       = 2'd0;
  localparam code_t ST_OVERFLOW = 2'd1;
  localparam code_t ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    idx_t   raddr;
  } mem_req_t;

  typedef struct packed {
    logic en;
    idx_t idx;
  } scan_ctrl_t;

endpackage

[hw/rtl/mpq_store.sv]
module mpq_store (
  input  logic              clk_i,
  input  mpq_pkg::mem_req_t req_i,
  output mpq_pkg::value_t   rdata_o
);

  mpq_pkg::value_t mem [mpq_pkg::DEPTH];
  mpq_pkg::value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mpq_scan.sv]
module mpq_scan (
  input  logic                clk_i,
  input  mpq_pkg::scan_ctrl_t ctrl_i,
  input  mpq_pkg::value_t     data_i,
  output mpq_pkg::value_t     best_o,
  output mpq_pkg::idx_t       pos_next_o
);

  mpq_pkg::value_t best_q, best_d;
  mpq_pkg::idx_t   pos_q, pos_d;
  logic            take;

  // first entry seeds the search; later ones replace only when strictly larger
  assign take = ctrl_i.en && ((ctrl_i.idx == '0) || (data_i > best_q));

  always_comb begin
    best_d = take ? data_i : best_q;
    pos_d  = take ? ctrl_i.idx : pos_q;
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    pos_q  <= pos_d;
  end

  assign best_o     = best_q;
  assign pos_next_o = pos_d;

endmodule

[hw/rtl/max_priority_queue_array.sv]
// Remove-max scans all N held entries for the maximum at position pos, then
// shifts the entries above pos down by one to close the gap.
// Throughput: one item at a time; the scan and the compaction share one
// memory read port, the scan uses one comparator, and each handles one entry per cycle.
// Reset: asynchronous active low; empties the queue and drops any result.
// Store contents are not cleared; only entries below the count are used.
`include "max_priority_queue_array_assert.svh"

module max_priority_queue_array (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mpq_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // value
  input  logic [1:0]                          s_axis_tuser,  // operation
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mpq_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,  // result_value, entry_count
  output logic [1:0]                          m_axis_tuser   // status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_SCAN,
    S_DRAIN,
    S_SHIFT,
    S_RESULT
  } state_e;

  state_e              state_q, state_d;
  mpq_pkg::idx_t       idx_q, idx_d;
  mpq_pkg::count_t     count_q, count_d;
  logic                wpend_q, wpend_d;
  mpq_pkg::idx_t       widx_q, widx_d;
  logic                cmp_en_q, cmp_en_d;
  mpq_pkg::idx_t       cmp_idx_q, cmp_idx_d;
  mpq_pkg::code_t      res_status_q, res_status_d;
  mpq_pkg::value_t     res_value_q, res_value_d;
  logic                out_valid_q, out_valid_d;
  mpq_pkg::code_t      out_status_q, out_status_d;
  mpq_pkg::value_t     out_value_q, out_value_d;
  mpq_pkg::count_t     out_count_q, out_count_d;

  mpq_pkg::mem_req_t   mem_req;
  mpq_pkg::value_t     rdata;
  mpq_pkg::scan_ctrl_t scan_ctrl;
  mpq_pkg::value_t     best;
  mpq_pkg::idx_t       pos_next;

  logic                accept;
  mpq_pkg::code_t      op;
  mpq_pkg::value_t     in_value;
  mpq_pkg::count_t     count_m1;
  mpq_pkg::count_t     idx_p1;
  logic                full;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser;
  assign in_value      = s_axis_tdata[mpq_pkg::VALUE_BITS-1:0];
  assign count_m1      = count_q - mpq_pkg::count_t'(1);
  assign idx_p1        = mpq_pkg::count_t'(idx_q) + mpq_pkg::count_t'(1);
  assign full          = (count_q == mpq_pkg::count_t'(mpq_pkg::DEPTH));

  always_comb begin
    mem_req.we    = wpend_q || (accept && (op == mpq_pkg::OP_INSERT) && !full);
    mem_req.waddr = wpend_q ? widx_q : count_q[mpq_pkg::IDX_BITS-1:0];
    mem_req.wdata = wpend_q ? rdata : in_value;
    unique case (state_q)
      S_SCAN:  mem_req.raddr = idx_q;
      S_SHIFT: mem_req.raddr = idx_p1[mpq_pkg::IDX_BITS-1:0];
      default: mem_req.raddr = '0;
    endcase
  end

  assign scan_ctrl.en  = cmp_en_q;
  assign scan_ctrl.idx = cmp_idx_q;

  mpq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  mpq_scan u_scan (
    .clk_i      (clk_i),
    .ctrl_i     (scan_ctrl),
    .data_i     (rdata),
    .best_o     (best),
    .pos_next_o (pos_next)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    wpend_d      = 1'b0;
    widx_d       = idx_q;
    cmp_en_d     = 1'b0;
    cmp_idx_d    = idx_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = mpq_pkg::ST_OK;
          res_value_d  = '0;
          state_d      = S_RESULT;
          case (op)
            mpq_pkg::OP_INSERT: begin
              if (full) begin
                res_status_d = mpq_pkg::ST_OVERFLOW;
              end else begin
                count_d = count_q + mpq_pkg::count_t'(1);
              end
            end
            mpq_pkg::OP_REMOVE: begin
              if (count_q == '0) begin
                res_status_d = mpq_pkg::ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            mpq_pkg::OP_PEEK: begin
              if (count_q == '0) begin
                res_status_d = mpq_pkg::ST_EMPTY;
              end else begin
                state_d = S_PEEK;
              end
            end
            default: ;
          endcase
        end
      end
      S_PEEK: begin
        res_value_d = rdata;
        state_d     = S_RESULT;
      end
      S_SCAN: begin
        cmp_en_d  = 1'b1;
        cmp_idx_d = idx_q;
        if (idx_q == count_m1[mpq_pkg::IDX_BITS-1:0]) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + mpq_pkg::idx_t'(1);
        end
      end
      S_DRAIN: begin
        idx_d   = pos_next;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (idx_p1 < count_q) begin
          wpend_d = 1'b1;
          widx_d  = idx_q;
          idx_d   = idx_p1[mpq_pkg::IDX_BITS-1:0];
        end else begin
          count_d      = count_m1;
          res_status_d = mpq_pkg::ST_OK;
          res_value_d  = best;
          state_d      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      count_q      <= '0;
      wpend_q      <= 1'b0;
      widx_q       <= '0;
      cmp_en_q     <= 1'b0;
      cmp_idx_q    <= '0;
      res_status_q <= mpq_pkg::ST_OK;
      res_value_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= mpq_pkg::ST_OK;
      out_value_q  <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      wpend_q      <= wpend_d;
      widx_q       <= widx_d;
      cmp_en_q     <= cmp_en_d;
      cmp_idx_q    <= cmp_idx_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_count_q  <= out_count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = mpq_pkg::OUT_TDATA_BITS'({out_count_q, out_value_q});

  `MPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= mpq_pkg::count_t'(mpq_pkg::DEPTH))
  `MPQ_ASSERT_IMP(a_overflow_full,
    out_valid_q && (out_status_q == mpq_pkg::ST_OVERFLOW),
    out_count_q == mpq_pkg::count_t'(mpq_pkg::DEPTH) && out_value_q == '0)
  `MPQ_ASSERT_IMP(a_empty_zero,
    out_valid_q && (out_status_q == mpq_pkg::ST_EMPTY),
    out_count_q == '0 && out_value_q == '0)
  `MPQ_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready)

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    HALF_PERIOD  = 10;
  localparam int    CYCLE_LIMIT  = 400000;
  localparam int    RANDOM_ITEMS = 1000;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    SETTLE       = 2 * mpq_pkg::DEPTH + 6;
  localparam mpq_pkg::code_t  OP_UNUSED = 2'd3;
  localparam mpq_pkg::value_t VAL_MAX = {1'b0, {(mpq_pkg::VALUE_BITS-1){1'b1}}};
  localparam mpq_pkg::value_t VAL_MIN = {1'b1, {(mpq_pkg::VALUE_BITS-1){1'b0}}};

  typedef struct {
    mpq_pkg::code_t  status;
    mpq_pkg::value_t value;
    mpq_pkg::count_t count;
  } outcome_t;

  class queue_mirror;
    mpq_pkg::value_t held[$];
    outcome_t        outcomes_due[$];
    int unsigned     errors;

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_request(mpq_pkg::code_t op, mpq_pkg::value_t v);
      outcome_t o;
      int       pos;
      o.status = mpq_pkg::ST_OK;
      o.value  = '0;
      case (op) inside
        mpq_pkg::OP_INSERT: begin
          if (held.size() >= mpq_pkg::DEPTH) o.status = mpq_pkg::ST_OVERFLOW;
          else held.push_back(v);
        end
        mpq_pkg::OP_REMOVE, mpq_pkg::OP_PEEK: begin
          if (held.size() == 0) begin
            o.status = mpq_pkg::ST_EMPTY;
          end else if (op == mpq_pkg::OP_PEEK) begin
            o.value = held[0];
          end else begin
            pos = 0;
            for (int i = 1; i < held.size(); i++)
              if (held[i] > held[pos]) pos = i;
            o.value = held[pos];
            held.delete(pos);
          end
        end
        default: ;
      endcase
      o.count = mpq_pkg::count_t'(held.size());
      outcomes_due.push_back(o);
    endfunction

    function void check_outcome(mpq_pkg::code_t st, mpq_pkg::value_t val,
                                mpq_pkg::count_t cnt);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        complain($sformatf("unexpected result: status %0d value %0d count %0d",
                           st, val, cnt));
        return;
      end
      want = outcomes_due.pop_front();
      if (st !== want.status)
        complain($sformatf("status mismatch: expected %0d, got %0d", want.status, st));
      if (val !== want.value)
        complain($sformatf("value mismatch: expected %0d, got %0d", want.value, val));
      if (cnt !== want.count)
        complain($sformatf("count mismatch: expected %0d, got %0d", want.count, cnt));
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [mpq_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic [1:0]                         s_axis_tuser;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [mpq_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [1:0]                         m_axis_tuser;

  queue_mirror board = new();
  bit          hold_off_req;
  bit          calm;

  max_priority_queue_array dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_outcome(mpq_pkg::code_t'(m_axis_tuser),
                          mpq_pkg::value_t'(m_axis_tdata[mpq_pkg::VALUE_BITS-1:0]),
                          mpq_pkg::count_t'(m_axis_tdata[mpq_pkg::VALUE_BITS +:
                                                         mpq_pkg::COUNT_BITS]));
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb NOT OK");
    $finish;
  end

  initial begin : sink
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic mpq_pkg::value_t random_value();
    case ($urandom_range(5))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return mpq_pkg::value_t'(int'($urandom_range(8)) - 4);
      default: return mpq_pkg::value_t'($urandom);
    endcase
  endfunction

  task automatic send_item(mpq_pkg::code_t op, mpq_pkg::value_t v);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= mpq_pkg::IN_TDATA_BITS'($unsigned(v));
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(op, v);
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= mpq_pkg::IN_TDATA_BITS'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_outcomes();
    s_axis_tvalid <= 1'b0;
    while (board.outcomes_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit             filling;
    mpq_pkg::code_t op;
    int             r;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= mpq_pkg::OP_INSERT;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!rst_ni) @(posedge clk_i);

    send_item(mpq_pkg::OP_PEEK, '0);
    send_item(mpq_pkg::OP_REMOVE, '0);
    send_item(OP_UNUSED, VAL_MAX);
    send_item(mpq_pkg::OP_INSERT, VAL_MAX);
    send_item(mpq_pkg::OP_INSERT, VAL_MIN);
    send_item(mpq_pkg::OP_INSERT, VAL_MAX);
    send_item(mpq_pkg::OP_INSERT, '1);
    send_item(mpq_pkg::OP_PEEK, VAL_MIN);
    send_item(mpq_pkg::OP_REMOVE, '0);
    send_item(mpq_pkg::OP_PEEK, '0);
    send_item(mpq_pkg::OP_REMOVE, '0);
    while (board.held.size() < mpq_pkg::DEPTH) send_item(mpq_pkg::OP_INSERT, random_value());
    send_item(mpq_pkg::OP_INSERT, VAL_MAX);
    send_item(OP_UNUSED, '0);

    filling = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS * 3 / 10) hold_off_req = 1'b1;
      if (i == RANDOM_ITEMS * 6 / 10) drain_outcomes();
      if (i == RANDOM_ITEMS * 85 / 100) calm = 1'b1;
      if (!calm && $urandom_range(3) == 0) pause_sender($urandom_range(17, 1));

      if (board.held.size() == mpq_pkg::DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      else if (board.held.size() == 0) filling = 1'b1;
      else if ($urandom_range(30) == 0) filling = !filling;

      r = $urandom_range(99);
      if (r < 5) op = OP_UNUSED;
      else if (r < 15) op = mpq_pkg::OP_PEEK;
      else if (r < 80) op = filling ? mpq_pkg::OP_INSERT : mpq_pkg::OP_REMOVE;
      else op = filling ? mpq_pkg::OP_REMOVE : mpq_pkg::OP_INSERT;
      send_item(op, random_value());
    end

    drain_outcomes();
    repeat (SETTLE) @(posedge clk_i);
    if (board.errors == 0 && board.outcomes_due.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end
endmodule
